@@ src/assert_macros.svh @@
// Assertion macros used by the RTL of the header dimension sniffer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ src/ihds_pkg.sv @@
// Package with the parse phases, byte codes and positions of the header dimension sniffer.
package ihds_pkg;

	typedef enum logic [3:0] {
		PH_SIG      = 4'd0,
		PH_PNG_SIG  = 4'd1,
		PH_PNG_DIM  = 4'd2,
		PH_JPG_SCAN = 4'd3,
		PH_JPG_MARK = 4'd4,
		PH_JPG_LENH = 4'd5,
		PH_JPG_LENL = 4'd6,
		PH_JPG_SKIP = 4'd7,
		PH_JPG_SOF  = 4'd8,
		PH_OK       = 4'd9,
		PH_FAIL     = 4'd10
	} phase_t;

	typedef logic [1:0] format_t;

	localparam format_t FMT_NONE = 2'd0;
	localparam format_t FMT_PNG  = 2'd1;
	localparam format_t FMT_JPEG = 2'd2;

	localparam logic [7:0] BYTE_PNG_0  = 8'h89;
	localparam logic [7:0] BYTE_PNG_1  = 8'h50;
	localparam logic [7:0] BYTE_PNG_2  = 8'h4E;
	localparam logic [7:0] BYTE_PNG_3  = 8'h47;
	localparam logic [7:0] BYTE_FF     = 8'hFF;
	localparam logic [7:0] MARK_SOI    = 8'hD8;
	localparam logic [7:0] MARK_SOF0   = 8'hC0;
	localparam logic [7:0] MARK_SOF1   = 8'hC1;
	localparam logic [7:0] MARK_SOF2   = 8'hC2;
	localparam logic [7:0] MARK_EOI    = 8'hD9;
	localparam logic [7:0] MARK_SOS    = 8'hDA;

	// Byte offsets within the file.
	localparam int POS_SIG_1       = 1;
	localparam int POS_SIG_2       = 2;
	localparam int POS_SIG_3       = 3;
	localparam int POS_PNG_W_FIRST = 16;
	localparam int POS_PNG_W_LAST  = 19;
	localparam int POS_PNG_H_FIRST = 20;
	localparam int POS_PNG_H_LAST  = 23;

	// Byte counts within a frame header segment.
	localparam logic [2:0] SOF_H_HI = 3'd3;
	localparam logic [2:0] SOF_H_LO = 3'd4;
	localparam logic [2:0] SOF_W_HI = 3'd5;
	localparam logic [2:0] SOF_W_LO = 3'd6;

endpackage

@@ src/image_header_dimension_sniffer_core.sv @@
// Top level of the image header dimension sniffer: byte parser and result register.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------
//  in      | input     | in_valid / in_ready | data_byte[7:0], last_byte
//  out     | output    | out_valid/out_ready | found, format[1:0], width, height
//
// Every byte is parsed by one level of combinational logic from the parser
// state registers straight into those registers and, when it decides the
// file, into the result register. The result register is the only thing
// that can hold the input back.
// Reset clears the parser state and empties the result register.
// A stalled output blocks input only while the result register is full.

`include "assert_macros.svh"

module image_header_dimension_sniffer_core #(
	parameter int HEADER_LENGTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic [1:0]  format,
	output logic [30:0] width,
	output logic [30:0] height
);

	// The byte position saturates at the header length, so it needs room for that value.
	localparam int PW = $clog2(HEADER_LENGTH + 1);
	localparam logic [PW-1:0] POS_HDR = PW'(HEADER_LENGTH);
	localparam logic [PW-1:0] POS_1   = PW'(ihds_pkg::POS_SIG_1);
	localparam logic [PW-1:0] POS_2   = PW'(ihds_pkg::POS_SIG_2);
	localparam logic [PW-1:0] POS_3   = PW'(ihds_pkg::POS_SIG_3);
	localparam logic [PW-1:0] POS_WF  = PW'(ihds_pkg::POS_PNG_W_FIRST);
	localparam logic [PW-1:0] POS_WL  = PW'(ihds_pkg::POS_PNG_W_LAST);
	localparam logic [PW-1:0] POS_HF  = PW'(ihds_pkg::POS_PNG_H_FIRST);
	localparam logic [PW-1:0] POS_HL  = PW'(ihds_pkg::POS_PNG_H_LAST);

	// Parser state.
	ihds_pkg::phase_t  phase_q, phase_d;
	logic [PW-1:0]     pos_q, pos_d;
	logic [31:0]       w_q, w_d;
	logic [31:0]       h_q, h_d;
	logic [2:0]        fbc_q, fbc_d;
	logic [7:0]        lenh_q, lenh_d;
	logic [15:0]       skip_q, skip_d;
	ihds_pkg::format_t fmt_q, fmt_d;
	logic              emitted_q, emitted_d;

	// Result register.
	logic              out_valid_q;
	logic              found_q;
	ihds_pkg::format_t format_q;
	logic [30:0]       width_q;
	logic [30:0]       height_q;

	logic              in_fire;
	logic              decided;
	logic              emit;
	logic              ok;
	logic [15:0]       seg_len;
	ihds_pkg::format_t res_fmt;
	logic [30:0]       res_w;
	logic [30:0]       res_h;

	// A new transaction is taken whenever the result register is free or is being emptied.
	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign decided   = (phase_q == ihds_pkg::PH_OK) || (phase_q == ihds_pkg::PH_FAIL);
	assign seg_len   = {lenh_q, data_byte};

	// Parser next state. Once the file is decided, bytes are only counted.
	always_comb begin
		phase_d   = phase_q;
		pos_d     = (pos_q < POS_HDR) ? pos_q + PW'(1) : pos_q;
		w_d       = w_q;
		h_d       = h_q;
		fbc_d     = fbc_q;
		lenh_d    = lenh_q;
		skip_d    = skip_q;
		fmt_d     = fmt_q;
		emitted_d = emitted_q;
		if (!decided) begin
			unique case (phase_q)
				ihds_pkg::PH_SIG: begin
					if (data_byte == ihds_pkg::BYTE_PNG_0) begin
						phase_d = ihds_pkg::PH_PNG_SIG;
					end else if (data_byte == ihds_pkg::BYTE_FF) begin
						phase_d = ihds_pkg::PH_JPG_MARK;
					end else begin
						phase_d = ihds_pkg::PH_FAIL;
					end
				end
				ihds_pkg::PH_PNG_SIG: begin
					if ((pos_q == POS_1 && data_byte == ihds_pkg::BYTE_PNG_1) ||
					    (pos_q == POS_2 && data_byte == ihds_pkg::BYTE_PNG_2)) begin
						phase_d = ihds_pkg::PH_PNG_SIG;
					end else if (pos_q == POS_3 && data_byte == ihds_pkg::BYTE_PNG_3) begin
						phase_d = ihds_pkg::PH_PNG_DIM;
					end else begin
						phase_d = ihds_pkg::PH_FAIL;
					end
				end
				ihds_pkg::PH_PNG_DIM: begin
					if (pos_q >= POS_WF && pos_q <= POS_WL) begin
						w_d = {w_q[23:0], data_byte};
					end else if (pos_q >= POS_HF && pos_q <= POS_HL) begin
						h_d = {h_q[23:0], data_byte};
					end
					if (pos_q == POS_HL) begin
						// Both dimensions must be positive as signed 32-bit values.
						if (w_d != 32'd0 && !w_d[31] && h_d != 32'd0 && !h_d[31]) begin
							phase_d = ihds_pkg::PH_OK;
							fmt_d   = ihds_pkg::FMT_PNG;
						end else begin
							phase_d = ihds_pkg::PH_FAIL;
						end
					end
				end
				ihds_pkg::PH_JPG_SCAN: begin
					if (data_byte == ihds_pkg::BYTE_FF) begin
						phase_d = ihds_pkg::PH_JPG_MARK;
					end
				end
				ihds_pkg::PH_JPG_MARK: begin
					if (pos_q == POS_1) begin
						// Second byte of the start-of-image signature.
						phase_d = (data_byte == ihds_pkg::MARK_SOI) ? ihds_pkg::PH_JPG_SCAN
						                                            : ihds_pkg::PH_FAIL;
					end else begin
						case (data_byte)
							ihds_pkg::BYTE_FF: begin
								phase_d = ihds_pkg::PH_JPG_MARK;
							end
							ihds_pkg::MARK_SOF0, ihds_pkg::MARK_SOF1,
							ihds_pkg::MARK_SOF2: begin
								fbc_d   = 3'd0;
								phase_d = ihds_pkg::PH_JPG_SOF;
							end
							ihds_pkg::MARK_EOI, ihds_pkg::MARK_SOS: begin
								phase_d = ihds_pkg::PH_FAIL;
							end
							default: begin
								phase_d = ihds_pkg::PH_JPG_LENH;
							end
						endcase
					end
				end
				ihds_pkg::PH_JPG_LENH: begin
					lenh_d  = data_byte;
					phase_d = ihds_pkg::PH_JPG_LENL;
				end
				ihds_pkg::PH_JPG_LENL: begin
					if (seg_len < 16'd2) begin
						phase_d = ihds_pkg::PH_FAIL;
					end else begin
						skip_d  = seg_len - 16'd2;
						phase_d = (seg_len == 16'd2) ? ihds_pkg::PH_JPG_SCAN
						                             : ihds_pkg::PH_JPG_SKIP;
					end
				end
				ihds_pkg::PH_JPG_SKIP: begin
					if (skip_q != 16'd0) begin
						skip_d = skip_q - 16'd1;
					end
					if (skip_d == 16'd0) begin
						phase_d = ihds_pkg::PH_JPG_SCAN;
					end
				end
				ihds_pkg::PH_JPG_SOF: begin
					if (fbc_q == ihds_pkg::SOF_H_HI || fbc_q == ihds_pkg::SOF_H_LO) begin
						h_d = {16'd0, h_q[7:0], data_byte};
					end else if (fbc_q == ihds_pkg::SOF_W_HI ||
					             fbc_q == ihds_pkg::SOF_W_LO) begin
						w_d = {16'd0, w_q[7:0], data_byte};
					end
					if (fbc_q >= ihds_pkg::SOF_W_LO) begin
						if (w_d != 32'd0 && h_d != 32'd0) begin
							phase_d = ihds_pkg::PH_OK;
							fmt_d   = ihds_pkg::FMT_JPEG;
						end else begin
							phase_d = ihds_pkg::PH_FAIL;
						end
					end else begin
						fbc_d = fbc_q + 3'd1;
					end
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end

		// A success waits until the whole header has arrived; a failure goes out at once,
		// and the last byte of a file forces a result, a failure unless a success is ready, if none was given yet.
		ok   = (phase_d == ihds_pkg::PH_OK) && (pos_d >= POS_HDR);
		emit = !emitted_q && (ok || (phase_d == ihds_pkg::PH_FAIL) || last_byte);
		if (emit) begin
			emitted_d = 1'b1;
		end

		// The result payload is taken here, before the last byte clears the parser.
		res_fmt = ok ? fmt_d : ihds_pkg::FMT_NONE;
		res_w   = ok ? w_d[30:0] : 31'd0;
		res_h   = ok ? h_d[30:0] : 31'd0;

		// The last byte returns the parser to its reset state for the next file.
		if (last_byte) begin
			phase_d   = ihds_pkg::PH_SIG;
			pos_d     = '0;
			w_d       = '0;
			h_d       = '0;
			fbc_d     = '0;
			lenh_d    = '0;
			skip_d    = '0;
			fmt_d     = ihds_pkg::FMT_NONE;
			emitted_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= ihds_pkg::PH_SIG;
			pos_q     <= '0;
			w_q       <= '0;
			h_q       <= '0;
			fbc_q     <= '0;
			lenh_q    <= '0;
			skip_q    <= '0;
			fmt_q     <= ihds_pkg::FMT_NONE;
			emitted_q <= 1'b0;
		end else if (in_fire) begin
			phase_q   <= phase_d;
			pos_q     <= pos_d;
			w_q       <= w_d;
			h_q       <= h_d;
			fbc_q     <= fbc_d;
			lenh_q    <= lenh_d;
			skip_q    <= skip_d;
			fmt_q     <= fmt_d;
			emitted_q <= emitted_d;
		end
	end

	// Result register: loaded by the transaction that produces a result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && emit) begin
			found_q  <= ok;
			format_q <= res_fmt;
			width_q  <= res_w;
			height_q <= res_h;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign format    = format_q;
	assign width     = width_q;
	assign height    = height_q;

	// A successful result always carries a known format and two non-zero dimensions.
	`ASSERT_SAME(a_found_payload, clk, arst_n, out_valid_q && found_q,
		format_q != ihds_pkg::FMT_NONE && width_q != 31'd0 && height_q != 31'd0)
	// A failure result is all zeros.
	`ASSERT_SAME(a_fail_payload, clk, arst_n, out_valid_q && !found_q,
		format_q == ihds_pkg::FMT_NONE && width_q == 31'd0 && height_q == 31'd0)
	// A success still held back means the header has not yet fully arrived.
	`ASSERT_SAME(a_held_success, clk, arst_n, phase_q == ihds_pkg::PH_OK && !emitted_q,
		pos_q < POS_HDR)
	// The last byte of a file leaves the parser ready for a fresh file.
	`ASSERT_NEXT(a_file_restart, clk, arst_n, in_fire && last_byte,
		pos_q == '0 && !emitted_q && phase_q == ihds_pkg::PH_SIG)

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the image header dimension sniffer core.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HDR_LEN      = 32;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_REPORTS  = 40;
	localparam int STALL_CYCLES = 400;

	// One result transaction as the block should present it.
	typedef struct {
		logic              found;
		ihds_pkg::format_t fmt;
		logic [30:0]       w;
		logic [30:0]       h;
	} dims_t;

	// The scoreboard carries its own copy of the parser. Every accepted byte
	// steps that parser, and any result the byte causes is queued here until
	// the block hands over its next result transaction.
	class dimension_scoreboard;
		dims_t             expected_dims[$];
		int                mismatches;
		int                hdr_len;
		int                file_pos;
		ihds_pkg::phase_t  phase;
		logic [31:0]       w_acc;
		logic [31:0]       h_acc;
		int                sof_count;
		logic [7:0]        len_hi;
		int                skip_left;
		bit                decided;
		bit                answered;
		ihds_pkg::format_t fmt_found;

		function new(int header_length);
			hdr_len = header_length;
			mismatches = 0;
			start_file();
		endfunction

		function void start_file();
			file_pos = 0;
			phase = ihds_pkg::PH_SIG;
			w_acc = '0;
			h_acc = '0;
			sof_count = 0;
			len_hi = '0;
			skip_left = 0;
			decided = 0;
			answered = 0;
			fmt_found = ihds_pkg::FMT_NONE;
		endfunction

		function void settle(bit ok, ihds_pkg::format_t f);
			decided = 1;
			phase = ok ? ihds_pkg::PH_OK : ihds_pkg::PH_FAIL;
			fmt_found = ok ? f : ihds_pkg::FMT_NONE;
		endfunction

		function void parse_byte(logic [7:0] b);
			int seg_len;
			case (phase)
				ihds_pkg::PH_SIG: begin
					if (b == ihds_pkg::BYTE_PNG_0)
						phase = ihds_pkg::PH_PNG_SIG;
					else if (b == ihds_pkg::BYTE_FF)
						phase = ihds_pkg::PH_JPG_MARK;
					else
						settle(0, ihds_pkg::FMT_NONE);
				end
				ihds_pkg::PH_PNG_SIG: begin
					if ((file_pos == ihds_pkg::POS_SIG_1 && b == ihds_pkg::BYTE_PNG_1) ||
					    (file_pos == ihds_pkg::POS_SIG_2 && b == ihds_pkg::BYTE_PNG_2)) begin
						// Still inside the signature.
					end else if (file_pos == ihds_pkg::POS_SIG_3 &&
					             b == ihds_pkg::BYTE_PNG_3) begin
						phase = ihds_pkg::PH_PNG_DIM;
					end else begin
						settle(0, ihds_pkg::FMT_NONE);
					end
				end
				ihds_pkg::PH_PNG_DIM: begin
					if (file_pos >= ihds_pkg::POS_PNG_W_FIRST &&
					    file_pos <= ihds_pkg::POS_PNG_W_LAST)
						w_acc = {w_acc[23:0], b};
					else if (file_pos >= ihds_pkg::POS_PNG_H_FIRST &&
					         file_pos <= ihds_pkg::POS_PNG_H_LAST)
						h_acc = {h_acc[23:0], b};
					// Both dimensions must be positive as signed 32-bit values.
					if (file_pos == ihds_pkg::POS_PNG_H_LAST)
						settle(w_acc != 0 && !w_acc[31] && h_acc != 0 && !h_acc[31],
							ihds_pkg::FMT_PNG);
				end
				ihds_pkg::PH_JPG_SCAN: begin
					if (b == ihds_pkg::BYTE_FF)
						phase = ihds_pkg::PH_JPG_MARK;
				end
				ihds_pkg::PH_JPG_MARK: begin
					if (file_pos == ihds_pkg::POS_SIG_1) begin
						if (b == ihds_pkg::MARK_SOI)
							phase = ihds_pkg::PH_JPG_SCAN;
						else
							settle(0, ihds_pkg::FMT_NONE);
					end else if (b == ihds_pkg::BYTE_FF) begin
						// A fill byte: the marker code is still to come.
					end else if (b == ihds_pkg::MARK_SOF0 || b == ihds_pkg::MARK_SOF1 ||
					             b == ihds_pkg::MARK_SOF2) begin
						sof_count = 0;
						phase = ihds_pkg::PH_JPG_SOF;
					end else if (b == ihds_pkg::MARK_EOI || b == ihds_pkg::MARK_SOS) begin
						settle(0, ihds_pkg::FMT_NONE);
					end else begin
						phase = ihds_pkg::PH_JPG_LENH;
					end
				end
				ihds_pkg::PH_JPG_LENH: begin
					len_hi = b;
					phase = ihds_pkg::PH_JPG_LENL;
				end
				ihds_pkg::PH_JPG_LENL: begin
					seg_len = int'({len_hi, b});
					if (seg_len < 2) begin
						settle(0, ihds_pkg::FMT_NONE);
					end else begin
						skip_left = seg_len - 2;
						phase = (skip_left == 0) ? ihds_pkg::PH_JPG_SCAN
						                         : ihds_pkg::PH_JPG_SKIP;
					end
				end
				ihds_pkg::PH_JPG_SKIP: begin
					if (skip_left > 0)
						skip_left--;
					if (skip_left == 0)
						phase = ihds_pkg::PH_JPG_SCAN;
				end
				ihds_pkg::PH_JPG_SOF: begin
					if (sof_count == ihds_pkg::SOF_H_HI || sof_count == ihds_pkg::SOF_H_LO)
						h_acc = {16'h0000, h_acc[7:0], b};
					else if (sof_count == ihds_pkg::SOF_W_HI ||
					         sof_count == ihds_pkg::SOF_W_LO)
						w_acc = {16'h0000, w_acc[7:0], b};
					if (sof_count >= ihds_pkg::SOF_W_LO)
						settle(w_acc != 0 && h_acc != 0, ihds_pkg::FMT_JPEG);
					else
						sof_count++;
				end
				default: begin
				end
			endcase
		endfunction

		// Notes one accepted input transaction.
		function void note_byte(logic [7:0] b, logic last);
			bit header_done;
			bit ok;
			dims_t d;
			if (!decided)
				parse_byte(b);
			if (file_pos < hdr_len)
				file_pos++;
			if (!answered) begin
				header_done = file_pos >= hdr_len;
				ok = decided && phase == ihds_pkg::PH_OK && header_done;
				// A success waits for the whole header; a failure goes out at
				// once, and the last byte forces a result if none went out yet.
				if (ok || (decided && phase == ihds_pkg::PH_FAIL) || last) begin
					d.found = ok;
					d.fmt = ok ? fmt_found : ihds_pkg::FMT_NONE;
					d.w = ok ? w_acc[30:0] : '0;
					d.h = ok ? h_acc[30:0] : '0;
					expected_dims.push_back(d);
					answered = 1;
				end
			end
			if (last)
				start_file();
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("MISMATCH at %0t ns: %s", $time, msg);
		endtask

		// Checks one accepted result transaction against the oldest expectation.
		task check_dims(logic f, ihds_pkg::format_t fm, logic [30:0] w, logic [30:0] h);
			dims_t d;
			if (expected_dims.size() == 0) begin
				report($sformatf("unexpected result: found %0b format %0d width %0d height %0d",
					f, fm, w, h));
			end else begin
				d = expected_dims.pop_front();
				if (f !== d.found)
					report($sformatf("found %0b, expected %0b", f, d.found));
				if (fm !== d.fmt)
					report($sformatf("format %0d, expected %0d", fm, d.fmt));
				if (w !== d.w)
					report($sformatf("width %0d, expected %0d", w, d.w));
				if (h !== d.h)
					report($sformatf("height %0d, expected %0d", h, d.h));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_ready;
	logic        found;
	logic [1:0]  format;
	logic [30:0] width;
	logic [30:0] height;

	dimension_scoreboard sniffer_model;
	logic [7:0]          file_buf[$];
	int                  send_idle_pct;
	int                  recv_idle_pct;
	int                  stall_request;
	int                  bytes_sent;
	int                  cycle_count;

	image_header_dimension_sniffer_core #(
		.HEADER_LENGTH(HDR_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found),
		.format(format),
		.width(width),
		.height(height)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Inputs change only just after a rising edge, so everything is settled by
	// the falling edge. Both handshakes are therefore judged at the falling
	// edge, for the transaction that the next rising edge completes.

	// Offers one byte, idling first at random, and waits for the transaction
	// to be taken. It returns in the time step of the accepting edge, so that
	// the next call may keep valid high without a gap.
	task automatic send_byte(logic [7:0] b, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		@(negedge clk);
		while (!in_ready)
			@(negedge clk);
		sniffer_model.note_byte(b, last);
		bytes_sent++;
		@(posedge clk);
	endtask

	task automatic send_file();
		for (int i = 0; i < file_buf.size(); i++)
			send_byte(file_buf[i], i == file_buf.size() - 1);
	endtask

	function automatic void put16(logic [15:0] v);
		file_buf.push_back(v[15:8]);
		file_buf.push_back(v[7:0]);
	endfunction

	function automatic void put32(logic [31:0] v);
		put16(v[31:16]);
		put16(v[15:0]);
	endfunction

	function automatic void pad_file(int n);
		while (file_buf.size() < n)
			file_buf.push_back(8'($urandom_range(255)));
	endfunction

	// PNG dimensions: mostly plausible sizes, with zero, the sign bit, the
	// largest positive value and wholly random words mixed in.
	function automatic logic [31:0] rand_dim32();
		case ($urandom_range(9))
			0: return 32'h0;
			1: return 32'h8000_0000 | $urandom;
			2: return 32'h7FFF_FFFF;
			3: return 32'h1;
			4: return $urandom;
			default: return $urandom_range(1, 5000);
		endcase
	endfunction

	function automatic logic [15:0] rand_dim16();
		case ($urandom_range(7))
			0: return 16'h0;
			1: return 16'hFFFF;
			2: return 16'h1;
			3: return 16'($urandom);
			default: return 16'($urandom_range(1, 4000));
		endcase
	endfunction

	function automatic void build_png();
		int bad_at;
		file_buf = {ihds_pkg::BYTE_PNG_0, ihds_pkg::BYTE_PNG_1, ihds_pkg::BYTE_PNG_2,
			ihds_pkg::BYTE_PNG_3};
		// Now and then one signature byte is spoilt by a single flipped bit.
		if ($urandom_range(7) == 0) begin
			bad_at = $urandom_range(3);
			file_buf[bad_at] = file_buf[bad_at] ^ (8'h01 << $urandom_range(7));
		end
		repeat (12)
			file_buf.push_back(8'($urandom_range(255)));
		put32(rand_dim32());
		put32(rand_dim32());
		pad_file($urandom_range(24, 44));
	endfunction

	function automatic void build_jpeg();
		int         seg_len;
		logic [7:0] mark;
		file_buf = {ihds_pkg::BYTE_FF};
		file_buf.push_back(($urandom_range(15) == 0) ? 8'($urandom_range(255))
		                                             : ihds_pkg::MARK_SOI);
		repeat ($urandom_range(3)) begin
			// Stray entropy-like bytes are passed over by the scan.
			repeat ($urandom_range(2))
				file_buf.push_back(8'($urandom_range(254)));
			file_buf.push_back(ihds_pkg::BYTE_FF);
			if ($urandom_range(3) == 0)
				file_buf.push_back(ihds_pkg::BYTE_FF);
			do
				mark = 8'($urandom_range(255));
			while (mark == ihds_pkg::BYTE_FF || mark == ihds_pkg::MARK_SOF0 ||
			       mark == ihds_pkg::MARK_SOF1 || mark == ihds_pkg::MARK_SOF2 ||
			       mark == ihds_pkg::MARK_EOI || mark == ihds_pkg::MARK_SOS);
			file_buf.push_back(mark);
			case ($urandom_range(9))
				0: seg_len = $urandom_range(1);
				1: seg_len = 2;
				// A length from the whole range: when long, the file ends while it is being skipped.
				2: seg_len = $urandom_range(65535);
				default: seg_len = $urandom_range(3, 12);
			endcase
			put16(16'(seg_len));
			repeat (seg_len > 12 ? 10 : (seg_len > 2 ? seg_len - 2 : 0))
				file_buf.push_back(8'($urandom_range(255)));
		end
		case ($urandom_range(7))
			0: begin
				file_buf.push_back(ihds_pkg::BYTE_FF);
				file_buf.push_back($urandom_range(1) ? ihds_pkg::MARK_EOI
				                                     : ihds_pkg::MARK_SOS);
			end
			1: begin
				// No frame header at all.
			end
			default: begin
				file_buf.push_back(ihds_pkg::BYTE_FF);
				if ($urandom_range(3) == 0)
					file_buf.push_back(ihds_pkg::BYTE_FF);
				case ($urandom_range(2))
					0: file_buf.push_back(ihds_pkg::MARK_SOF0);
					1: file_buf.push_back(ihds_pkg::MARK_SOF1);
					default: file_buf.push_back(ihds_pkg::MARK_SOF2);
				endcase
				put16(16'($urandom_range(8, 17)));
				file_buf.push_back(8'($urandom_range(255)));
				put16(rand_dim16());
				put16(rand_dim16());
			end
		endcase
		pad_file($urandom_range(20, 48));
	endfunction

	function automatic void build_noise();
		file_buf.delete();
		case ($urandom_range(3))
			0: file_buf.push_back(ihds_pkg::BYTE_PNG_0);
			1: file_buf.push_back(ihds_pkg::BYTE_FF);
			default: begin
			end
		endcase
		pad_file($urandom_range(1, 40));
	endfunction

	// Most files are well formed with random content; a few are cut short.
	task automatic send_random_files(int byte_goal);
		int goal;
		int cut;
		goal = bytes_sent + byte_goal;
		while (bytes_sent < goal) begin
			case ($urandom_range(9))
				0, 1, 2, 3: build_png();
				9: build_noise();
				default: build_jpeg();
			endcase
			if ($urandom_range(9) == 0) begin
				cut = $urandom_range(1, file_buf.size());
				while (file_buf.size() > cut)
					void'(file_buf.pop_back());
			end
			send_file();
		end
	endtask

	task automatic send_directed_files();
		// PNG with the largest positive width, exactly one header long.
		file_buf = {ihds_pkg::BYTE_PNG_0, ihds_pkg::BYTE_PNG_1, ihds_pkg::BYTE_PNG_2,
			ihds_pkg::BYTE_PNG_3};
		repeat (12)
			file_buf.push_back(8'h00);
		put32(32'h7FFF_FFFF);
		put32(32'h0000_0001);
		pad_file(HDR_LEN);
		send_file();
		// PNG width with the sign bit set: refused at the last height byte.
		file_buf = {ihds_pkg::BYTE_PNG_0, ihds_pkg::BYTE_PNG_1, ihds_pkg::BYTE_PNG_2,
			ihds_pkg::BYTE_PNG_3};
		repeat (12)
			file_buf.push_back(8'hFF);
		put32(32'h8000_0000);
		put32(32'h0000_0010);
		pad_file(26);
		send_file();
		// Good PNG dimensions, but the file stops short of the header length.
		file_buf = {ihds_pkg::BYTE_PNG_0, ihds_pkg::BYTE_PNG_1, ihds_pkg::BYTE_PNG_2,
			ihds_pkg::BYTE_PNG_3};
		repeat (12)
			file_buf.push_back(8'h5A);
		put32(32'd640);
		put32(32'd480);
		send_file();
		// JPEG with a fill byte, a segment of length two, a short segment,
		// stray data and a progressive frame header of the largest size.
		file_buf = {ihds_pkg::BYTE_FF, ihds_pkg::MARK_SOI, ihds_pkg::BYTE_FF,
			ihds_pkg::BYTE_FF, 8'hE0, 8'h00, 8'h02,
			ihds_pkg::BYTE_FF, 8'hE1, 8'h00, 8'h04, 8'hAA, 8'hBB, 8'h00, 8'h12,
			ihds_pkg::BYTE_FF, ihds_pkg::MARK_SOF2, 8'h00, 8'h11, 8'h08,
			8'hFF, 8'hFF, 8'hFF, 8'hFF};
		pad_file(40);
		send_file();
		// End of image before any frame header; trailing bytes are ignored.
		file_buf = {ihds_pkg::BYTE_FF, ihds_pkg::MARK_SOI, ihds_pkg::BYTE_FF,
			ihds_pkg::MARK_EOI, 8'h01, 8'h02, 8'h03};
		send_file();
		// Start of scan before any frame header, ending on that byte.
		file_buf = {ihds_pkg::BYTE_FF, ihds_pkg::MARK_SOI, ihds_pkg::BYTE_FF,
			ihds_pkg::MARK_SOS};
		send_file();
		// Segment length below two.
		file_buf = {ihds_pkg::BYTE_FF, ihds_pkg::MARK_SOI, ihds_pkg::BYTE_FF, 8'hE0,
			8'h00, 8'h01, 8'h00};
		send_file();
		// Baseline frame header with a zero width.
		file_buf = {ihds_pkg::BYTE_FF, ihds_pkg::MARK_SOI, ihds_pkg::BYTE_FF,
			ihds_pkg::MARK_SOF0, 8'h00, 8'h11, 8'h08, 8'h00, 8'h10, 8'h00, 8'h00};
		pad_file(HDR_LEN);
		send_file();
		// Extended frame header with small dimensions, padded past the header.
		file_buf = {ihds_pkg::BYTE_FF, ihds_pkg::MARK_SOI, ihds_pkg::BYTE_FF,
			ihds_pkg::MARK_SOF1, 8'h00, 8'h11, 8'h08, 8'h00, 8'h01, 8'h00, 8'h01};
		pad_file(HDR_LEN + 3);
		send_file();
		// One-byte file, an unknown signature and a broken start of image.
		file_buf = {ihds_pkg::BYTE_PNG_0};
		send_file();
		file_buf = {8'h00, 8'h89, 8'h50};
		send_file();
		file_buf = {ihds_pkg::BYTE_FF, 8'h00, 8'hD8};
		send_file();
	endtask

	// The receiver draws its ready at every rising edge. A stall request
	// turns into a long hold-off, counted down here while the sender keeps
	// offering bytes, so the result register fills and input is held back.
	initial begin
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_request > 0) begin
				hold_left = stall_request;
				stall_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready)
			sniffer_model.check_dims(found, format, width, height);
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		last_byte = 1'b0;
		send_idle_pct = 25;
		recv_idle_pct = 75;
		stall_request = 0;
		bytes_sent = 0;
		sniffer_model = new(HDR_LEN);
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sender mostly busy, receiver mostly stalled.
		send_directed_files();
		send_random_files(230);

		// Sender mostly idle, receiver mostly ready.
		send_idle_pct = 75;
		recv_idle_pct = 25;
		send_random_files(230);

		// No idling, opened by one long receiver hold-off.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_request = STALL_CYCLES;
		send_random_files(230);
		in_valid <= 1'b0;

		while (sniffer_model.expected_dims.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		if (sniffer_model.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
